// File: design/swnd_pkg.sv
`timescale 1ns / 1ps
package swnd_pkg;

   localparam int WindowKBits   = 7;
   localparam int ToleranceBits = 32;
   localparam int CsrIndexBits  = 2;
   localparam int CsrDataBits   = 32;

   typedef logic [CsrIndexBits-1:0]  csr_index_type;
   typedef logic [CsrDataBits-1:0]   csr_data_type;
   typedef logic [WindowKBits-1:0]   window_k_type;
   typedef logic [ToleranceBits-1:0] tolerance_type;

   localparam csr_index_type REG_WINDOW_K  = 2'd0;
   localparam csr_index_type REG_TOLERANCE = 2'd1;

   localparam window_k_type  WindowKReset   = 7'd1;
   localparam tolerance_type ToleranceReset = 32'd0;

   typedef struct packed {
      logic shift;
      logic compare_en;
   } cell_ctrl_type;

endpackage

// File: design/swnd_req_if.sv
`timescale 1ns / 1ps
interface swnd_req_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          start_req;

   modport source (output valid, output sample, output start_req, input ready);
   modport sink (input valid, input sample, input start_req, output ready);
endinterface

// File: design/swnd_rsp_if.sv
`timescale 1ns / 1ps
interface swnd_rsp_if;
   logic valid;
   logic ready;
   logic near_dup;
   logic found_so_far;

   modport source (output valid, output near_dup, output found_so_far, input ready);
   modport sink (input valid, input near_dup, input found_so_far, output ready);
endinterface

// File: design/swnd_csr_if.sv
`timescale 1ns / 1ps
interface swnd_csr_if;
   logic                   valid;
   logic                   ready;
   swnd_pkg::csr_index_type index;
   swnd_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/swnd_cell.sv
`timescale 1ns / 1ps
module swnd_cell #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                    clock,
   input  swnd_pkg::cell_ctrl_type ctrl,
   input  logic [SAMPLE_BITS-1:0]  cur_sample,
   input  logic [SAMPLE_BITS-1:0]  prev_sample,
   input  swnd_pkg::tolerance_type tolerance,
   output logic [SAMPLE_BITS-1:0]  held_sample,
   output logic                    hit
);
   localparam int CmpBits = (SAMPLE_BITS > swnd_pkg::ToleranceBits) ?
                            SAMPLE_BITS : swnd_pkg::ToleranceBits;

   logic [SAMPLE_BITS-1:0] data_ff;
   logic                   hit_ff;
   logic                   hit_in;
   logic                   cur_ge;
   logic [SAMPLE_BITS-1:0] diff;

   always_comb begin
      cur_ge = $signed(cur_sample) >= $signed(data_ff);
      diff   = cur_ge ? (cur_sample - data_ff) : (data_ff - cur_sample);
      hit_in = ctrl.compare_en && (CmpBits'(diff) <= CmpBits'(tolerance));
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= prev_sample;
         hit_ff  <= hit_in;
      end
   end

   assign held_sample = data_ff;
   assign hit         = hit_ff;
endmodule

// File: design/sliding_window_near_duplicate.sv
`timescale 1ns / 1ps
// Sliding-window near-duplicate detector.
// req_chan: one transaction per sample (sample, start_req). start_req opens a
// new sequence: the window is emptied and the sticky flag cleared first.
// rsp_chan: one transaction per sample (near_dup, found_so_far), in order.
// csr_chan: register writes, index 0 = window_k, index 1 = tolerance; ready
// whenever reset is low, to be used only while no sample is in flight.
// Samples shift through a row of MAX_WINDOW cells; each cell compares the
// incoming sample against its stored one in the accept cycle and registers
// the hit. The registered hits are OR-reduced into the output register.
// Throughput: one sample per cycle while rsp is not stalled.
// rsp stall: the output register holds; one more sample is still taken into
// the cell stage if it is empty, after which req ready drops until rsp is taken.
// Reset: window empty, sticky flag clear, window_k = 1, tolerance = 0; no
// clearing pass, the block is ready in the cycle after reset.
module sliding_window_near_duplicate #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   swnd_req_if.sink     req_chan,
   swnd_rsp_if.source   rsp_chan,
   swnd_csr_if.sink     csr_chan
);
   localparam int FillBits = $clog2(MAX_WINDOW + 1);
   localparam int SpanBits = (FillBits > swnd_pkg::WindowKBits) ?
                             FillBits : swnd_pkg::WindowKBits;

   swnd_pkg::window_k_type  window_k_ff;
   swnd_pkg::tolerance_type tolerance_ff;

   logic [FillBits-1:0] fill_ff;
   logic [FillBits-1:0] fill_in;
   logic                s1_valid_ff;
   logic                s1_start_ff;
   logic                rsp_valid_ff;
   logic                near_dup_ff;
   logic                found_ff;

   logic                accept;
   logic                out_load;
   logic                hit_any;
   logic [SpanBits-1:0] span;
   logic [SpanBits-1:0] fill_eff;
   logic [SpanBits-1:0] k_cap;

   logic [SAMPLE_BITS-1:0] chain [MAX_WINDOW+1];
   logic [MAX_WINDOW-1:0]  hits;

   assign out_load         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !reset && (!s1_valid_ff || out_load);
   assign accept           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = !reset;

   always_comb begin
      fill_eff = req_chan.start_req ? '0 : SpanBits'(fill_ff);
      k_cap    = (SpanBits'(window_k_ff) > SpanBits'(MAX_WINDOW)) ?
                 SpanBits'(MAX_WINDOW) : SpanBits'(window_k_ff);
      span     = (k_cap < fill_eff) ? k_cap : fill_eff;
      if (req_chan.start_req) begin
         fill_in = FillBits'(1);
      end else if (fill_ff == FillBits'(MAX_WINDOW)) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + FillBits'(1);
      end
   end

   assign chain[0] = req_chan.sample;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swnd_pkg::cell_ctrl_type ctrl;
      assign ctrl.shift      = accept;
      assign ctrl.compare_en = SpanBits'(i) < span;
      swnd_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cur_sample  (req_chan.sample),
         .prev_sample (chain[i]),
         .tolerance   (tolerance_ff),
         .held_sample (chain[i+1]),
         .hit         (hits[i])
      );
   end

   assign hit_any = |hits;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_k_ff  <= swnd_pkg::WindowKReset;
         tolerance_ff <= swnd_pkg::ToleranceReset;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            swnd_pkg::REG_WINDOW_K: begin
               window_k_ff <= csr_chan.data[swnd_pkg::WindowKBits-1:0];
            end
            swnd_pkg::REG_TOLERANCE: begin
               tolerance_ff <= csr_chan.data[swnd_pkg::ToleranceBits-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            found_ff     <= s1_start_ff ? hit_any : (found_ff || hit_any);
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_start_ff <= req_chan.start_req;
      end
      if (out_load) begin
         near_dup_ff <= hit_any;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.near_dup     = near_dup_ff;
   assign rsp_chan.found_so_far = found_ff;
endmodule

// File: design/swnd_checker.sv
`timescale 1ns / 1ps
module swnd_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_near_dup,
   input logic rsp_found
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_dup_sets_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_near_dup |-> rsp_found)
      else $error("near_dup without found_so_far");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with no pending rsp transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_near_dup) && $stable(rsp_found))
      else $error("stalled rsp transaction changed");
endmodule

bind sliding_window_near_duplicate swnd_checker u_swnd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_near_dup (rsp_chan.near_dup),
   .rsp_found    (rsp_chan.found_so_far)
);
